@@ sv/integer_square_root_core_assert.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the integer square root core
// Shared concurrent checks, clocked on clk and held off during reset.
// ---------------------------------------------------------------------------
`ifndef INTEGER_SQUARE_ROOT_CORE_ASSERT_SVH
`define INTEGER_SQUARE_ROOT_CORE_ASSERT_SVH

// Same-cycle implication.
`define ISR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ISR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/isr_pkg.sv @@
// ---------------------------------------------------------------------------
// isr_pkg
// Widths, constants, controller states and command word of the root core.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package isr_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int ROOT_BITS  = 16;
  // result bits produced, one per iteration; odd widths get a zero pad bit
  localparam int ITERS      = (DATA_WIDTH + 1) / 2;
  localparam int SQ_W       = 2 * ITERS;
  localparam int REM_W      = ITERS + 1;
  localparam int CNT_W      = $clog2(ITERS);

  localparam logic [CNT_W-1:0]     CNT_LAST  = CNT_W'(ITERS - 1);
  localparam logic [ROOT_BITS-1:0] FAIL_ROOT = ROOT_BITS'(1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_WAIT
  } isr_state_t;

  typedef struct packed {
    logic load;       // capture a new operand
    logic step;       // one restoring iteration
    logic emit_step;  // write result word from the final iteration
    logic emit_hold;  // write result word from the held root
  } isr_cmd_t;

endpackage

@@ sv/isr_in_if.sv @@
// ---------------------------------------------------------------------------
// isr_in_if
// Operand channel: valid/ready with one signed operand word.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface isr_in_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [isr_pkg::DATA_WIDTH-1:0]  value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

@@ sv/isr_out_if.sv @@
// ---------------------------------------------------------------------------
// isr_out_if
// Result channel: valid/ready with root and invalid flag.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface isr_out_if;
  logic                            valid;
  logic                            ready;
  logic [isr_pkg::ROOT_BITS-1:0]   root;
  logic                            invalid;

  modport source (output valid, output root, output invalid, input ready);
  modport sink   (input valid, input root, input invalid, output ready);
endinterface

@@ sv/integer_square_root_core.sv @@
// ---------------------------------------------------------------------------
// integer_square_root_core
// Floor square root of a signed operand; negative operands flag invalid.
// ---------------------------------------------------------------------------
//  channel   dir   fields                      handshake
//  in_ch     in    value[31:0] signed          valid/ready
//  out_ch    out   root[15:0], invalid         valid/ready
//
//  Each operand passes through a load step, then 16 iterations of the
//  restoring root step (one root bit each, compare and subtract).
//  Result words sit in an output register; a new operand is taken while the
//  previous word waits. If that word is still unread when the next root is
//  done, the root is held until the output register frees up.
//  Synchronous active-low reset clears the sequencer and the output valid.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module integer_square_root_core (
  input  logic       clk,
  input  logic       rst_n,
  isr_in_if.sink     in_ch,
  isr_out_if.source  out_ch
);

  isr_pkg::isr_cmd_t cmd;

  isr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  isr_dp u_dp (
    .clk         (clk),
    .cmd         (cmd),
    .in_value    (in_ch.value),
    .out_root    (out_ch.root),
    .out_invalid (out_ch.invalid)
  );

endmodule

@@ sv/isr_ctrl.sv @@
// ---------------------------------------------------------------------------
// isr_ctrl
// Sequencer: operand load, iteration count, result word handoff.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "integer_square_root_core_assert.svh"

module isr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output isr_pkg::isr_cmd_t cmd
);

  isr_pkg::isr_state_t            state_r, state_nxt;
  logic [isr_pkg::CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic                           slot_free;
  logic                           last;

  assign slot_free = !out_valid_r || out_ready;
  assign last      = (cnt_r == isr_pkg::CNT_LAST);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      isr_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = isr_pkg::ST_CALC;
      end
      isr_pkg::ST_CALC: begin
        if (last) state_nxt = slot_free ? isr_pkg::ST_IDLE : isr_pkg::ST_WAIT;
      end
      isr_pkg::ST_WAIT: begin
        if (slot_free) state_nxt = isr_pkg::ST_IDLE;
      end
      default: state_nxt = isr_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      isr_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      isr_pkg::ST_CALC: begin
        cmd.step      = 1'b1;
        cmd.emit_step = last && slot_free;
      end
      isr_pkg::ST_WAIT: begin
        cmd.emit_hold = slot_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.load) cnt_nxt = '0;
    else if (cmd.step) cnt_nxt = cnt_r + 1'b1;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit_step || cmd.emit_hold) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= isr_pkg::ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  `ISR_ASSERT_NEXT(a_load_starts_calc, in_valid && in_ready, (state_r == isr_pkg::ST_CALC) && (cnt_r == '0), "load did not start iteration count")
  `ISR_ASSERT_NOW(a_no_overwrite, cmd.emit_step || cmd.emit_hold, !out_valid_r || out_ready, "pending result word overwritten")
  `ISR_ASSERT_NEXT(a_stall_to_wait, (state_r == isr_pkg::ST_CALC) && last && !slot_free, state_r == isr_pkg::ST_WAIT, "finished root not held while output stalled")
  `ISR_ASSERT_NOW(a_valid_source, $rose(out_valid_r), ($past(state_r) == isr_pkg::ST_CALC) || ($past(state_r) == isr_pkg::ST_WAIT), "result word raised outside finish")

endmodule

@@ sv/isr_dp.sv @@
// ---------------------------------------------------------------------------
// isr_dp
// Restoring square root datapath, one root bit per step, plus result register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module isr_dp (
  input  logic                                  clk,
  input  isr_pkg::isr_cmd_t                     cmd,
  input  logic signed [isr_pkg::DATA_WIDTH-1:0] in_value,
  output logic [isr_pkg::ROOT_BITS-1:0]         out_root,
  output logic                                  out_invalid
);

  localparam int SQ_W  = isr_pkg::SQ_W;
  localparam int REM_W = isr_pkg::REM_W;
  localparam int ITERS = isr_pkg::ITERS;

  logic [SQ_W-1:0]                 x_r, x_nxt;
  logic [REM_W-1:0]                rem_r, rem_nxt;
  logic [ITERS-1:0]                root_r, root_nxt;
  logic                            neg_r;
  logic [isr_pkg::ROOT_BITS-1:0]   out_root_r;
  logic                            out_invalid_r;

  logic [REM_W+1:0]                rem_shift;
  logic [REM_W+1:0]                trial;
  logic [REM_W+1:0]                diff;
  logic                            ge;
  logic [ITERS-1:0]                step_root;
  logic [ITERS-1:0]                fin_root;

  // bring down the next two operand bits, try (root << 2) | 1
  assign rem_shift = {rem_r, x_r[SQ_W-1 -: 2]};
  assign trial     = (REM_W+2)'({root_r, 2'b01});
  assign diff      = rem_shift - trial;
  assign ge        = (rem_shift >= trial);
  assign step_root = {root_r[ITERS-2:0], ge};

  always_comb begin
    x_nxt    = x_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    if (cmd.load) begin
      x_nxt    = SQ_W'($unsigned(in_value));
      rem_nxt  = '0;
      root_nxt = '0;
    end else if (cmd.step) begin
      x_nxt    = {x_r[SQ_W-3:0], 2'b00};
      rem_nxt  = ge ? REM_W'(diff) : REM_W'(rem_shift);
      root_nxt = step_root;
    end
  end

  assign fin_root = cmd.emit_step ? step_root : root_r;

  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
    if (cmd.load) neg_r <= in_value[isr_pkg::DATA_WIDTH-1];
    if (cmd.emit_step || cmd.emit_hold) begin
      out_root_r    <= neg_r ? isr_pkg::FAIL_ROOT : isr_pkg::ROOT_BITS'(fin_root);
      out_invalid_r <= neg_r;
    end
  end

  assign out_root    = out_root_r;
  assign out_invalid = out_invalid_r;

endmodule
